@@ sv/sfcp_pkg.sv @@
// Package for the sensor frame CRC parser: request/response types, frame
// constants and the CRC-8 byte update. No dependencies.
package sfcp_pkg;

   localparam int WORD_W       = 16;
   localparam int NUM_RAW      = 6;             // words passed through unchanged
   localparam int NUM_IDX      = 2;             // index words divided by ten
   localparam int IDX_MAG_W    = 12;            // 32768 / 10 fits in 12 bits

   localparam logic [7:0]  CRC_INIT      = 8'hFF;
   localparam logic [7:0]  CRC_POLY      = 8'h31;
   localparam logic [15:0] INDEX_INVALID = 16'h7FFF;
   localparam logic [15:0] RECIP_TEN     = 16'hCCCD;   // ceil(2^19 / 10)
   localparam int          RECIP_SHIFT   = 19;

   // byte role inside a three-byte word group
   localparam logic [1:0] PHASE_HIGH = 2'd0;
   localparam logic [1:0] PHASE_LOW  = 2'd1;
   localparam logic [1:0] PHASE_CRC  = 2'd2;

   localparam logic [2:0] FIRST_IDX_WORD = 3'd6;
   localparam logic [2:0] LAST_WORD      = 3'd7;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       frame_start;
   } req_type;

   typedef struct packed {
      logic                status;
      logic [15:0]         pm1_value;
      logic [15:0]         pm2p5_value;
      logic [15:0]         pm4_value;
      logic [15:0]         pm10_value;
      logic signed [15:0]  humidity_ticks;
      logic signed [15:0]  temperature_ticks;
      logic signed [15:0]  voc_value;
      logic signed [15:0]  nox_value;
   } rsp_type;

   // CRC-8, MSB first, no reflection
   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int k = 0; k < 8; k++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

@@ sv/sensor_frame_crc_parser_top.sv @@
// Sensor frame CRC parser top level: byte-wise 24-byte frame checker and record builder.
// Depends on sfcp_pkg for the request/response types, constants and CRC function.
//
// A byte request is registered in the input register and processed from there; the record
// for the 24th byte is loaded into the record register, which drives rsp_valid.
// Throughput: one byte per cycle; a stalled record holds only the 24th byte of the next frame.
// Reset (synchronous, active high) clears frame position, error flag and both valid flags.
module sensor_frame_crc_parser_top
   import sfcp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   // input register
   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;

   // frame tracking
   logic [1:0] phase_ff, phase_in;
   logic [2:0] word_idx_ff, word_idx_in;
   logic [7:0] high_ff, high_in;
   logic [7:0] crc_ff, crc_in;
   logic       err_ff, err_in;

   // stored words: six raw words, two index words kept as sign/magnitude
   logic [WORD_W-1:0]    word_ff [NUM_RAW];
   logic [IDX_MAG_W-1:0] idx_mag_ff [NUM_IDX];
   logic                 idx_neg_ff [NUM_IDX];
   logic                 idx_inv_ff [NUM_IDX];

   // result register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   // processing stage
   logic [1:0]        cur_phase;
   logic [2:0]        cur_word;
   logic              cur_err;
   logic              is_final;
   logic              advance;
   logic              out_blocked;
   logic              store_raw;
   logic              store_idx;
   logic [WORD_W-1:0] new_word;
   logic [WORD_W-1:0] new_abs;
   logic [31:0]       recip_prod;
   logic              idx_slot;
   logic              crc_bad;

   // ------------------------------------------------------------------
   // Handshake: the input register moves on unless it holds the last byte
   // of a frame while the record register is still full and stalled.
   // ------------------------------------------------------------------
   assign out_blocked = rsp_valid_ff && rsp_stall;
   assign advance     = in_valid_ff && !(is_final && out_blocked);
   assign req_stall   = in_valid_ff && !advance;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_data    = rsp_data_ff;

   // frame start restarts position and error flag before this byte is used
   assign cur_phase = in_data_ff.frame_start ? PHASE_HIGH : phase_ff;
   assign cur_word  = in_data_ff.frame_start ? 3'd0 : word_idx_ff;
   assign cur_err   = in_data_ff.frame_start ? 1'b0 : err_ff;
   assign is_final  = (cur_word == LAST_WORD) && (cur_phase == PHASE_CRC);

   assign new_word  = {high_ff, in_data_ff.rx_byte};
   assign crc_bad   = (crc_ff != in_data_ff.rx_byte);
   assign store_raw = advance && (cur_phase == PHASE_LOW) && (cur_word < FIRST_IDX_WORD);
   assign store_idx = advance && (cur_phase == PHASE_LOW) && (cur_word >= FIRST_IDX_WORD);
   assign idx_slot  = cur_word[0];

   // Divide by ten: magnitude times ceil(2^19/10), exact over all 16-bit magnitudes.
   // The sign is put back when the record is built.
   assign new_abs    = new_word[WORD_W-1] ? WORD_W'(-new_word) : new_word;
   assign recip_prod = 32'(new_abs) * 32'(RECIP_TEN);

   always_comb begin
      phase_in    = phase_ff;
      word_idx_in = word_idx_ff;
      high_in     = high_ff;
      crc_in      = crc_ff;
      err_in      = err_ff;
      if (advance) begin
         err_in = cur_err;
         case (cur_phase)
            PHASE_HIGH: begin
               high_in  = in_data_ff.rx_byte;
               crc_in   = crc8_byte(CRC_INIT, in_data_ff.rx_byte);
               phase_in = PHASE_LOW;
            end
            PHASE_LOW: begin
               crc_in   = crc8_byte(crc_ff, in_data_ff.rx_byte);
               phase_in = PHASE_CRC;
            end
            PHASE_CRC: begin
               err_in   = cur_err | crc_bad;
               crc_in   = CRC_INIT;
               phase_in = PHASE_HIGH;
            end
            default: begin
               phase_in = PHASE_HIGH;
            end
         endcase
         if (cur_phase == PHASE_CRC) begin
            word_idx_in = cur_word + 3'd1;   // wraps to word 0 after the last group
         end else begin
            word_idx_in = cur_word;
         end
         // drop the error flag once the record has taken it
         if (is_final) begin
            err_in = 1'b0;
         end
      end
   end

   // Build the record on the final byte; a checksum failure in any group sets status and zeroes every other field.
   always_comb begin
      rsp_data_in = '0;
      if (cur_err || crc_bad) begin
         rsp_data_in.status = 1'b1;
      end else begin
         rsp_data_in.status            = 1'b0;
         rsp_data_in.pm1_value         = word_ff[0];
         rsp_data_in.pm2p5_value       = word_ff[1];
         rsp_data_in.pm4_value         = word_ff[2];
         rsp_data_in.pm10_value        = word_ff[3];
         rsp_data_in.humidity_ticks    = word_ff[4];
         rsp_data_in.temperature_ticks = word_ff[5];
         rsp_data_in.voc_value         = idx_inv_ff[0] ? INDEX_INVALID :
                                         idx_neg_ff[0] ? -WORD_W'(idx_mag_ff[0]) :
                                                          WORD_W'(idx_mag_ff[0]);
         rsp_data_in.nox_value         = idx_inv_ff[1] ? INDEX_INVALID :
                                         idx_neg_ff[1] ? -WORD_W'(idx_mag_ff[1]) :
                                                          WORD_W'(idx_mag_ff[1]);
      end
   end

   always_comb begin
      // hold the input register while it is stalled, refill on accept
      if (req_valid && !req_stall) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      // record register: load on the final byte, clear once taken
      if (advance && is_final) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= PHASE_HIGH;
         word_idx_ff  <= 3'd0;
         crc_ff       <= CRC_INIT;
         err_ff       <= 1'b0;
         high_ff      <= 8'd0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
         word_idx_ff  <= word_idx_in;
         crc_ff       <= crc_in;
         err_ff       <= err_in;
         high_ff      <= high_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_data_ff <= req_data;
      end
      if (advance && is_final) begin
         rsp_data_ff <= rsp_data_in;
      end
      if (store_raw) begin
         word_ff[cur_word] <= new_word;
      end
      if (store_idx) begin
         idx_mag_ff[idx_slot] <= recip_prod[RECIP_SHIFT +: IDX_MAG_W];
         idx_neg_ff[idx_slot] <= new_word[WORD_W-1];
         idx_inv_ff[idx_slot] <= (new_word == INDEX_INVALID);
      end
   end

`ifndef SYNTH
   // the final byte never overwrites a record that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (advance && is_final) |-> !out_blocked)
      else $error("record register overwritten while stalled");

   // the phase counter only takes the three byte roles
   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PHASE_HIGH) || (phase_ff == PHASE_LOW) || (phase_ff == PHASE_CRC))
      else $error("phase counter out of range");

   // after the final byte the frame position is back at its start
   a_wrap: assert property (@(posedge clock) disable iff (reset)
      (advance && is_final) |=> (word_idx_ff == 3'd0) && (phase_ff == PHASE_HIGH) && !err_ff)
      else $error("frame position did not wrap after final byte");

   // an error record carries zero in the pm1, voc, nox and humidity fields
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.status) |->
         (rsp_data_ff.pm1_value == 16'd0) && (rsp_data_ff.voc_value == 16'sd0) &&
         (rsp_data_ff.nox_value == 16'sd0) && (rsp_data_ff.humidity_ticks == 16'sd0))
      else $error("error record with nonzero fields");
`endif

endmodule
